// File: rtl/sdi_pkg.sv
`default_nettype none

package sdi_pkg;

	typedef logic [2:0] cmd_t;

	localparam cmd_t CMD_GO_IDLE  = 3'd0;
	localparam cmd_t CMD_IF_COND  = 3'd1;
	localparam cmd_t CMD_APP      = 3'd2;
	localparam cmd_t CMD_OP_COND  = 3'd3;
	localparam cmd_t CMD_READ_OCR = 3'd4;

	localparam logic [7:0] IDLE_BYTE     = 8'hFF;
	localparam logic [7:0] CMD_PREFIX    = 8'h40;
	localparam logic [7:0] CRC_IF_COND   = 8'h87;
	localparam logic [7:0] CRC_DEFAULT   = 8'h95;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [7:0] R1_READY      = 8'h00;
	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_OP_COND  = 32'h4000_0000;
	localparam logic [2:0] FRAME_LEN     = 3'd6;
	localparam logic [7:0] GAP_BYTES     = 8'd2;
	localparam logic [7:0] OCR_BYTES     = 8'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_CARD  = 2'd1;
	localparam logic [1:0] STATUS_OP_TMO   = 2'd2;

	localparam logic [1:0] KIND_V1   = 2'd1;
	localparam logic [1:0] KIND_HC   = 2'd2;
	localparam logic [1:0] KIND_SC   = 2'd3;

	localparam logic [1:0] REG_PREAMBLE   = 2'd0;
	localparam logic [1:0] REG_IDLE_RETRY = 2'd1;
	localparam logic [1:0] REG_CMD_RETRY  = 2'd2;
	localparam logic [1:0] REG_RESP_WAIT  = 2'd3;

	localparam logic [7:0] RST_PREAMBLE   = 8'd11;
	localparam logic [7:0] RST_IDLE_RETRY = 8'd32;
	localparam logic [7:0] RST_CMD_RETRY  = 8'd254;
	localparam logic [7:0] RST_RESP_WAIT  = 8'd255;

	typedef struct packed {
		logic [7:0] preamble_bytes;
		logic [7:0] idle_retry_limit;
		logic [7:0] cmd_retry_limit;
		logic [7:0] response_wait_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       select_card;
		logic       finished;
		logic [1:0] status_code;
		logic [1:0] card_kind;
		logic       high_capacity;
	} res_t;

	function automatic logic [5:0] cmd_number(input cmd_t c);
		logic [5:0] n;
		case (c)
			CMD_GO_IDLE:  n = 6'd0;
			CMD_IF_COND:  n = 6'd8;
			CMD_APP:      n = 6'd55;
			CMD_OP_COND:  n = 6'd41;
			default:      n = 6'd58;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] cmd_start_byte(input cmd_t c);
		return CMD_PREFIX | {2'b00, cmd_number(c)};
	endfunction

endpackage

`default_nettype wire

// File: rtl/sdi_frame.sv
`default_nettype none

module sdi_frame (
	input  wire sdi_pkg::cmd_t cmd,
	input  wire logic [2:0]    idx,
	output logic [7:0]         frame_byte
);
	import sdi_pkg::*;

	logic [31:0] arg;

	always_comb begin
		case (cmd)
			CMD_IF_COND: arg = ARG_IF_COND;
			CMD_OP_COND: arg = ARG_OP_COND;
			default:     arg = 32'd0;
		endcase
	end

	always_comb begin
		case (idx)
			3'd0: frame_byte = cmd_start_byte(cmd);
			3'd1: frame_byte = arg[31:24];
			3'd2: frame_byte = arg[23:16];
			3'd3: frame_byte = arg[15:8];
			3'd4: frame_byte = arg[7:0];
			default: frame_byte = (cmd == CMD_IF_COND) ? CRC_IF_COND : CRC_DEFAULT;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/sdi_seq.sv
`default_nettype none

module sdi_seq (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic         action,
	input  wire logic [7:0]   rx_byte,
	input  wire sdi_pkg::cfg_t cfg,
	output sdi_pkg::res_t     res
);
	import sdi_pkg::*;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_PRE   = 4'd1;
	localparam logic [3:0] PH_CMD   = 4'd2;
	localparam logic [3:0] PH_POLL  = 4'd3;
	localparam logic [3:0] PH_OCR   = 4'd4;
	localparam logic [3:0] PH_TRAIL = 4'd5;
	localparam logic [3:0] PH_GAP   = 4'd6;
	localparam logic [3:0] PH_DONE0 = 4'd7;
	localparam logic [3:0] PH_DONE1 = 4'd8;
	localparam logic [3:0] PH_DONE2 = 4'd9;

	logic [3:0] phase_q, phase_d;
	logic [7:0] byte_idx_q, byte_idx_d;
	logic [7:0] wait_q, wait_d;
	logic [8:0] attempt_q, attempt_d;
	logic       v2_q, v2_d;
	logic [1:0] kind_q, kind_d;
	logic       cap_q, cap_d;
	logic [7:0] last_q, last_d;
	cmd_t       cmd_q, cmd_d;

	logic [7:0] byte_inc;
	logic [8:0] attempt_inc;
	logic       idle_over;
	logic       cmd_over;
	logic [7:0] frame_byte;
	logic       start_cmd;
	cmd_t       start_code;
	logic       emit_done;
	logic [7:0] tx;
	logic       sel;
	logic [1:0] code;

	assign byte_inc    = byte_idx_q + 8'd1;
	assign attempt_inc = attempt_q + 9'd1;
	assign idle_over   = attempt_inc > {1'b0, cfg.idle_retry_limit};
	assign cmd_over    = attempt_inc > {1'b0, cfg.cmd_retry_limit};

	sdi_frame u_frame (
		.cmd        (cmd_q),
		.idx        (byte_inc[2:0]),
		.frame_byte (frame_byte)
	);

	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		wait_d     = wait_q;
		attempt_d  = attempt_q;
		v2_d       = v2_q;
		kind_d     = kind_q;
		cap_d      = cap_q;
		last_d     = last_q;
		cmd_d      = cmd_q;
		start_cmd  = 1'b0;
		start_code = CMD_GO_IDLE;
		emit_done  = 1'b0;
		tx         = IDLE_BYTE;
		sel        = 1'b1;

		if (!action) begin
			v2_d       = 1'b1;
			attempt_d  = 9'd0;
			byte_idx_d = 8'd0;
			wait_d     = 8'd0;
			last_d     = IDLE_BYTE;
			if (cfg.preamble_bytes != 8'd0) begin
				phase_d = PH_PRE;
				sel     = 1'b0;
			end else begin
				start_cmd = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_PRE: begin
					byte_idx_d = byte_inc;
					if (byte_inc < cfg.preamble_bytes) begin
						sel = 1'b0;
					end else begin
						start_cmd = 1'b1;
					end
				end
				PH_CMD: begin
					byte_idx_d = byte_inc;
					if (byte_inc < {5'd0, FRAME_LEN}) begin
						tx = frame_byte;
					end else begin
						phase_d = PH_POLL;
						wait_d  = 8'd0;
					end
				end
				PH_POLL: begin
					if (rx_byte == IDLE_BYTE && wait_q < cfg.response_wait_limit) begin
						wait_d = wait_q + 8'd1;
					end else begin
						last_d = rx_byte;
						if (rx_byte == R1_READY && cmd_q == CMD_READ_OCR) begin
							phase_d    = PH_OCR;
							byte_idx_d = 8'd0;
						end else begin
							phase_d = PH_TRAIL;
						end
					end
				end
				PH_OCR: begin
					if (byte_idx_q == 8'd0) begin
						cap_d = rx_byte[6];
					end
					byte_idx_d = byte_inc;
					if (byte_inc >= OCR_BYTES) begin
						phase_d = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					case (cmd_q)
						CMD_GO_IDLE: begin
							attempt_d = attempt_inc;
							if (idle_over) begin
								phase_d   = PH_DONE1;
								emit_done = 1'b1;
							end else if (last_q == R1_IDLE) begin
								attempt_d  = 9'd0;
								phase_d    = PH_GAP;
								byte_idx_d = 8'd0;
								sel        = 1'b0;
							end else begin
								start_cmd = 1'b1;
							end
						end
						CMD_IF_COND: begin
							attempt_d = attempt_inc;
							start_cmd = 1'b1;
							if (cmd_over) begin
								v2_d       = 1'b0;
								kind_d     = KIND_V1;
								attempt_d  = 9'd0;
								start_code = CMD_APP;
							end else if (last_q != R1_IDLE) begin
								start_code = CMD_IF_COND;
							end else begin
								attempt_d  = 9'd0;
								start_code = CMD_APP;
							end
						end
						CMD_APP: begin
							start_cmd  = 1'b1;
							start_code = CMD_OP_COND;
						end
						CMD_OP_COND: begin
							attempt_d = attempt_inc;
							if (cmd_over) begin
								phase_d   = PH_DONE2;
								emit_done = 1'b1;
							end else if (last_q != R1_READY) begin
								start_cmd  = 1'b1;
								start_code = CMD_APP;
							end else begin
								attempt_d = 9'd0;
								cap_d     = 1'b0;
								if (v2_q) begin
									start_cmd  = 1'b1;
									start_code = CMD_READ_OCR;
								end else begin
									phase_d   = PH_DONE0;
									emit_done = 1'b1;
								end
							end
						end
						default: begin
							attempt_d = attempt_inc;
							if (cmd_over || last_q == R1_READY) begin
								kind_d    = cap_q ? KIND_HC : KIND_SC;
								phase_d   = PH_DONE0;
								emit_done = 1'b1;
							end else begin
								start_cmd  = 1'b1;
								start_code = CMD_READ_OCR;
							end
						end
					endcase
				end
				PH_GAP: begin
					byte_idx_d = byte_inc;
					if (byte_inc < GAP_BYTES) begin
						sel = 1'b0;
					end else begin
						start_cmd  = 1'b1;
						start_code = CMD_IF_COND;
					end
				end
				default: begin
					emit_done = 1'b1;
				end
			endcase
		end

		if (start_cmd) begin
			cmd_d      = start_code;
			phase_d    = PH_CMD;
			byte_idx_d = 8'd0;
			wait_d     = 8'd0;
			tx         = cmd_start_byte(start_code);
			sel        = 1'b1;
		end

		case (phase_d)
			PH_DONE1: code = STATUS_NO_CARD;
			PH_DONE2: code = STATUS_OP_TMO;
			default:  code = STATUS_OK;
		endcase

		if (emit_done) begin
			res.tx_byte       = 8'd0;
			res.select_card   = 1'b0;
			res.finished      = 1'b1;
			res.status_code   = code;
			res.card_kind     = kind_d;
			res.high_capacity = cap_d;
		end else begin
			res.tx_byte       = tx;
			res.select_card   = sel;
			res.finished      = 1'b0;
			res.status_code   = STATUS_OK;
			res.card_kind     = 2'd0;
			res.high_capacity = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			byte_idx_q <= 8'd0;
			wait_q     <= 8'd0;
			attempt_q  <= 9'd0;
			v2_q       <= 1'b1;
			kind_q     <= 2'd0;
			cap_q      <= 1'b0;
			last_q     <= IDLE_BYTE;
			cmd_q      <= CMD_GO_IDLE;
		end else if (step) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			wait_q     <= wait_d;
			attempt_q  <= attempt_d;
			v2_q       <= v2_d;
			kind_q     <= kind_d;
			cap_q      <= cap_d;
			last_q     <= last_d;
			cmd_q      <= cmd_d;
		end
	end

	a_byte_idx_frame: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CMD |-> byte_idx_q < {5'd0, FRAME_LEN})
		else $error("frame byte index out of range");

	a_ocr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OCR |-> byte_idx_q < OCR_BYTES)
		else $error("ocr byte index out of range");

	a_attempt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DONE1 && phase_q != PH_DONE2 && phase_q != PH_IDLE
		&& phase_q != PH_DONE0 |-> attempt_q <= 9'd255)
		else $error("attempt count ran past the retry range");

endmodule

`default_nettype wire

// File: rtl/sd_spi_card_initializer_unit.sv
// SD card SPI-mode initialization sequencer.
// Input channel (in_valid/in_ready): action 0 starts the power-up sequence,
// action 1 reports a finished byte exchange together with the byte read back.
// Output channel (out_valid/out_ready): one result per input transaction,
// giving the next byte to shift out and the chip-select level, or, once the
// sequence ends, finished with status, card kind and capacity flag.
// An accepted transaction passes the input register, the decision logic and
// the result register before its result is shown.
// Throughput: one transaction per cycle while the receiver does not stall;
// the decision logic reads and updates its state on each step, so back-to-back items are taken.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; in_ready then drops until out_ready returns.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at the next
// edge and are meant to be issued only while no transaction is in flight.
// Reset clears both pipeline stages, loads the register defaults and leaves
// the sequencer idle; an exchange before any start reports finished, status 0.
`default_nettype none

module sd_spi_card_initializer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      tx_byte,
	output logic            select_card,
	output logic            finished,
	output logic [1:0]      status_code,
	output logic [1:0]      card_kind,
	output logic            high_capacity,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import sdi_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] rx_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_bytes      <= RST_PREAMBLE;
			cfg_q.idle_retry_limit    <= RST_IDLE_RETRY;
			cfg_q.cmd_retry_limit     <= RST_CMD_RETRY;
			cfg_q.response_wait_limit <= RST_RESP_WAIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREAMBLE:   cfg_q.preamble_bytes      <= cfg_data;
				REG_IDLE_RETRY: cfg_q.idle_retry_limit    <= cfg_data;
				REG_CMD_RETRY:  cfg_q.cmd_retry_limit     <= cfg_data;
				default:        cfg_q.response_wait_limit <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			rx_s1     <= rx_byte;
		end
	end

	sdi_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.action  (action_s1),
		.rx_byte (rx_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign tx_byte       = res_s2.tx_byte;
	assign select_card   = res_s2.select_card;
	assign finished      = res_s2.finished;
	assign status_code   = res_s2.status_code;
	assign card_kind     = res_s2.card_kind;
	assign high_capacity = res_s2.high_capacity;

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> tx_byte == 8'd0 && !select_card)
		else $error("finished result carries a byte to send");

	a_busy_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> status_code == STATUS_OK && card_kind == 2'd0
		&& !high_capacity)
		else $error("status reported before the sequence ended");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_code != 2'd3)
		else $error("undefined status code");

	a_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> out_valid)
		else $error("pending transaction did not reach the result register");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

// File: tb/tb_sd_spi_card_initializer_unit.sv
`timescale 1ns / 100ps

module tb_sd_spi_card_initializer_unit;
	import sdi_pkg::*;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 8;

	localparam logic [5:0] NUM_GO_IDLE  = 6'd0;
	localparam logic [5:0] NUM_IF_COND  = 6'd8;
	localparam logic [5:0] NUM_APP      = 6'd55;
	localparam logic [5:0] NUM_OP_COND  = 6'd41;
	localparam logic [5:0] NUM_READ_OCR = 6'd58;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PRE,
		PH_CMD,
		PH_POLL,
		PH_OCR,
		PH_TRAIL,
		PH_GAP,
		PH_DONE_OK,
		PH_DONE_NOCARD,
		PH_DONE_TMO
	} init_phase_e;

	typedef struct {
		init_phase_e phase;
		logic [7:0]  byte_idx;
		logic [8:0]  poll_cnt;
		logic [8:0]  tries;
		logic        v2_card;
		logic [1:0]  kind;
		logic        hc_flag;
		logic [7:0]  r1;
		cmd_t        cmd;
	} card_seq_t;

	typedef struct packed {
		logic       act;
		logic [7:0] rx;
	} xfer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       action = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] tx_byte;
	logic       select_card;
	logic       finished;
	logic [1:0] status_code;
	logic [1:0] card_kind;
	logic       high_capacity;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'h00;

	sd_spi_card_initializer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tx_byte      (tx_byte),
		.select_card  (select_card),
		.finished     (finished),
		.status_code  (status_code),
		.card_kind    (card_kind),
		.high_capacity(high_capacity),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfg_t      cfg_shadow;
	card_seq_t model_st;
	card_seq_t gen_st;
	xfer_t     pending_xfers[$];
	res_t      expected_replies[$];
	int unsigned fails = 0;

	function automatic logic [7:0] frame_byte(input cmd_t c, input logic [7:0] idx);
		logic [31:0] arg;
		logic [31:0] shifted;
		logic [5:0]  num;
		arg = 32'h0;
		case (c)
			CMD_GO_IDLE: num = NUM_GO_IDLE;
			CMD_IF_COND: begin
				num = NUM_IF_COND;
				arg = ARG_IF_COND;
			end
			CMD_APP: num = NUM_APP;
			CMD_OP_COND: begin
				num = NUM_OP_COND;
				arg = ARG_OP_COND;
			end
			default: num = NUM_READ_OCR;
		endcase
		if (idx == 8'd0)
			return CMD_PREFIX | {2'b00, num};
		if (idx >= 8'd5)
			return (c == CMD_IF_COND) ? CRC_IF_COND : CRC_DEFAULT;
		shifted = arg >> (8 * (4 - idx));
		return shifted[7:0];
	endfunction

	function automatic res_t send_res(input logic [7:0] tx, input logic sel);
		res_t r;
		r = '0;
		r.tx_byte = tx;
		r.select_card = sel;
		return r;
	endfunction

	function automatic res_t done_res(input card_seq_t s);
		res_t r;
		r = '0;
		r.finished = 1'b1;
		r.status_code = (s.phase == PH_DONE_NOCARD) ? STATUS_NO_CARD :
			(s.phase == PH_DONE_TMO) ? STATUS_OP_TMO : STATUS_OK;
		r.card_kind = s.kind;
		r.high_capacity = s.hc_flag;
		return r;
	endfunction

	function automatic res_t end_seq(inout card_seq_t s, input init_phase_e p);
		s.phase = p;
		return done_res(s);
	endfunction

	function automatic res_t start_cmd(inout card_seq_t s, input cmd_t c);
		s.cmd = c;
		s.phase = PH_CMD;
		s.byte_idx = 8'd0;
		s.poll_cnt = 9'd0;
		return send_res(frame_byte(c, 8'd0), 1'b1);
	endfunction

	function automatic res_t cmd_complete(inout card_seq_t s, input cfg_t c);
		s.tries = s.tries + 9'd1;
		case (s.cmd)
			CMD_GO_IDLE: begin
				if (s.tries > c.idle_retry_limit)
					return end_seq(s, PH_DONE_NOCARD);
				if (s.r1 != R1_IDLE)
					return start_cmd(s, CMD_GO_IDLE);
				s.tries = 9'd0;
				s.phase = PH_GAP;
				s.byte_idx = 8'd0;
				return send_res(IDLE_BYTE, 1'b0);
			end
			CMD_IF_COND: begin
				if (s.tries > c.cmd_retry_limit) begin
					s.v2_card = 1'b0;
					s.kind = KIND_V1;
				end else if (s.r1 != R1_IDLE) begin
					return start_cmd(s, CMD_IF_COND);
				end
				s.tries = 9'd0;
				return start_cmd(s, CMD_APP);
			end
			CMD_APP: begin
				s.tries = s.tries - 9'd1;
				return start_cmd(s, CMD_OP_COND);
			end
			CMD_OP_COND: begin
				if (s.tries > c.cmd_retry_limit)
					return end_seq(s, PH_DONE_TMO);
				if (s.r1 != R1_READY)
					return start_cmd(s, CMD_APP);
				s.tries = 9'd0;
				s.hc_flag = 1'b0;
				if (s.v2_card)
					return start_cmd(s, CMD_READ_OCR);
				return end_seq(s, PH_DONE_OK);
			end
			default: begin
				if (s.tries > c.cmd_retry_limit || s.r1 == R1_READY) begin
					s.kind = s.hc_flag ? KIND_HC : KIND_SC;
					return end_seq(s, PH_DONE_OK);
				end
				return start_cmd(s, CMD_READ_OCR);
			end
		endcase
	endfunction

	function automatic res_t init_step(inout card_seq_t s, input cfg_t c,
			input logic act, input logic [7:0] rx);
		res_t r;
		if (!act) begin
			s.v2_card = 1'b1;
			s.tries = 9'd0;
			s.byte_idx = 8'd0;
			s.poll_cnt = 9'd0;
			s.r1 = IDLE_BYTE;
			if (c.preamble_bytes != 8'd0) begin
				s.phase = PH_PRE;
				return send_res(IDLE_BYTE, 1'b0);
			end
			return start_cmd(s, CMD_GO_IDLE);
		end
		case (s.phase)
			PH_PRE: begin
				s.byte_idx = s.byte_idx + 8'd1;
				if (s.byte_idx < c.preamble_bytes)
					r = send_res(IDLE_BYTE, 1'b0);
				else
					r = start_cmd(s, CMD_GO_IDLE);
			end
			PH_CMD: begin
				s.byte_idx = s.byte_idx + 8'd1;
				if (s.byte_idx < FRAME_LEN) begin
					r = send_res(frame_byte(s.cmd, s.byte_idx), 1'b1);
				end else begin
					s.phase = PH_POLL;
					s.poll_cnt = 9'd0;
					r = send_res(IDLE_BYTE, 1'b1);
				end
			end
			PH_POLL: begin
				if (rx == IDLE_BYTE && s.poll_cnt < c.response_wait_limit) begin
					s.poll_cnt = s.poll_cnt + 9'd1;
				end else begin
					s.r1 = rx;
					if (rx == R1_READY && s.cmd == CMD_READ_OCR) begin
						s.phase = PH_OCR;
						s.byte_idx = 8'd0;
					end else begin
						s.phase = PH_TRAIL;
					end
				end
				r = send_res(IDLE_BYTE, 1'b1);
			end
			PH_OCR: begin
				if (s.byte_idx == 8'd0)
					s.hc_flag = rx[6];
				s.byte_idx = s.byte_idx + 8'd1;
				if (s.byte_idx >= OCR_BYTES)
					s.phase = PH_TRAIL;
				r = send_res(IDLE_BYTE, 1'b1);
			end
			PH_TRAIL: r = cmd_complete(s, c);
			PH_GAP: begin
				s.byte_idx = s.byte_idx + 8'd1;
				if (s.byte_idx < GAP_BYTES)
					r = send_res(IDLE_BYTE, 1'b0);
				else
					r = start_cmd(s, CMD_IF_COND);
			end
			default: r = done_res(s);
		endcase
		return r;
	endfunction

	function automatic card_seq_t seq_reset();
		card_seq_t s;
		s.phase = PH_IDLE;
		s.byte_idx = 8'd0;
		s.poll_cnt = 9'd0;
		s.tries = 9'd0;
		s.v2_card = 1'b1;
		s.kind = 2'd0;
		s.hc_flag = 1'b0;
		s.r1 = IDLE_BYTE;
		s.cmd = CMD_GO_IDLE;
		return s;
	endfunction

	// mostly short gaps, a few long ones, and quiet stretches with none
	function automatic int unsigned gap_len(inout int unsigned quiet);
		int unsigned p;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 2)
			quiet = $urandom_range(30, 150);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// card behavior, so that most runs get deep into the sequence
	function automatic logic [7:0] card_reply(input card_seq_t s);
		int unsigned p;
		p = $urandom_range(0, 99);
		if (s.phase == PH_OCR)
			return 8'($urandom);
		if (s.phase != PH_POLL)
			return (p < 70) ? IDLE_BYTE : 8'($urandom);
		if (p < 30)
			return IDLE_BYTE;
		p = $urandom_range(0, 99);
		case (s.cmd)
			CMD_GO_IDLE:  return (p < 85) ? R1_IDLE : 8'($urandom);
			CMD_IF_COND:  return (p < 75) ? R1_IDLE : 8'($urandom);
			CMD_OP_COND:  return (p < 60) ? R1_READY : (p < 90) ? R1_IDLE : 8'($urandom);
			CMD_READ_OCR: return (p < 85) ? R1_READY : 8'($urandom);
			default:      return (p < 70) ? R1_IDLE : 8'($urandom);
		endcase
	endfunction

	task automatic push_xfer(input logic act, input logic [7:0] rx);
		xfer_t x;
		x.act = act;
		x.rx = rx;
		pending_xfers.push_back(x);
		void'(init_step(gen_st, cfg_shadow, act, rx));
	endtask

	task automatic push_random(input int unsigned n);
		logic act;
		for (int unsigned i = 0; i < n; i++) begin
			act = 1'b1;
			if (gen_st.phase == PH_IDLE || gen_st.phase >= PH_DONE_OK) begin
				if ($urandom_range(0, 99) < 85)
					act = 1'b0;
			end else if ($urandom_range(0, 149) == 0) begin
				act = 1'b0;
			end
			push_xfer(act, act ? card_reply(gen_st) : 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_xfers.size() != 0 || in_valid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sender holds off halfway until every reply is back
	task automatic run_random(input int unsigned n);
		push_random(n / 2);
		wait_drained();
		push_random(n - n / 2);
		wait_drained();
	endtask

	task automatic write_cfg(input cfg_t c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PREAMBLE;
		cfg_data <= c.preamble_bytes;
		@(posedge clk);
		cfg_index <= REG_IDLE_RETRY;
		cfg_data <= c.idle_retry_limit;
		@(posedge clk);
		cfg_index <= REG_CMD_RETRY;
		cfg_data <= c.cmd_retry_limit;
		@(posedge clk);
		cfg_index <= REG_RESP_WAIT;
		cfg_data <= c.response_wait_limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	function automatic cfg_t rand_cfg(input int unsigned hi);
		cfg_t c;
		c.preamble_bytes = 8'($urandom_range(0, hi));
		c.idle_retry_limit = 8'($urandom_range(0, hi));
		c.cmd_retry_limit = 8'($urandom_range(0, hi));
		c.response_wait_limit = 8'($urandom_range(0, hi));
		return c;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fails++;
		end
	endtask

	// driver
	int unsigned send_gap = 0;
	int unsigned send_quiet = 0;
	xfer_t       next_xfer;
	res_t        predicted;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted = init_step(model_st, cfg_shadow, action, rx_byte);
				expected_replies.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_xfers.size() != 0) begin
					next_xfer = pending_xfers.pop_front();
					in_valid <= 1'b1;
					action <= next_xfer.act;
					rx_byte <= next_xfer.rx;
					send_gap = gap_len(send_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int unsigned stall_left = 0;
	int unsigned stall_quiet = 0;
	res_t        want;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual tx %0h",
						$time, tx_byte);
					fails++;
				end else begin
					want = expected_replies.pop_front();
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("select_card", 8'(want.select_card), 8'(select_card));
					check_field("finished", 8'(want.finished), 8'(finished));
					check_field("status_code", 8'(want.status_code), 8'(status_code));
					check_field("card_kind", 8'(want.card_kind), 8'(card_kind));
					check_field("high_capacity", 8'(want.high_capacity), 8'(high_capacity));
				end
			end
			out_ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			else if ($urandom_range(0, 3) == 0)
				stall_left = gap_len(stall_quiet);
		end
	end

	// watchdog
	int unsigned dead_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(pending_xfers.size() == 0 && !in_valid && expected_replies.size() == 0))
			dead_cycles = 0;
		else
			dead_cycles++;
		if (dead_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		cfg_shadow.preamble_bytes = RST_PREAMBLE;
		cfg_shadow.idle_retry_limit = RST_IDLE_RETRY;
		cfg_shadow.cmd_retry_limit = RST_CMD_RETRY;
		cfg_shadow.response_wait_limit = RST_RESP_WAIT;
		model_st = seq_reset();
		gen_st = seq_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// exchange before any start
		push_xfer(1'b1, 8'h00);
		run_random(350);

		// all limits at zero
		c = '0;
		write_cfg(c);
		push_xfer(1'b0, 8'hFF);
		push_xfer(1'b1, 8'h00);
		push_xfer(1'b1, 8'hFF);
		push_xfer(1'b1, 8'h5A);
		push_xfer(1'b1, 8'hA5);
		push_xfer(1'b1, 8'h80);
		// idle byte comes with the CRC; 7F is R1, limit exceeded
		push_xfer(1'b1, R1_IDLE);
		push_xfer(1'b1, 8'h7F);
		push_xfer(1'b1, 8'hFF);
		push_xfer(1'b0, 8'h00);
		push_xfer(1'b1, 8'h01);
		// restart in the middle of a command
		push_xfer(1'b0, 8'hFF);
		push_xfer(1'b1, 8'h33);
		run_random(150);

		c = '1;
		write_cfg(c);
		run_random(300);

		repeat (2) begin
			write_cfg(rand_cfg(3));
			run_random(350);
		end

		write_cfg(rand_cfg(255));
		run_random(300);

		wait_drained();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
